/* src/cdq_pkg.sv */
// Shared types and constants for the circular deque block.
`default_nettype none
package cdq_pkg;

   localparam int DATA_W    = 32;
   localparam int FUNC_W    = 3;
   localparam int CAP_W     = 5;
   localparam int DEPTH_DEF = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FN_PUSH_REAR  = 3'd1;
   localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FN_POP_REAR   = 3'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic take;
      logic read;
   } cmd_type;

endpackage
`default_nettype wire

/* src/cdq_slot_ram.sv */
// Slot store: one write port, two registered read ports.
`default_nettype none
module cdq_slot_ram #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
   input  wire                                clock,
   input  wire                                wr_en,
   input  wire [$clog2(DEPTH)-1:0]            wr_addr,
   input  wire [cdq_pkg::DATA_W-1:0]          wr_data,
   input  wire                                rd_en,
   input  wire [$clog2(DEPTH)-1:0]            rd_addr_a,
   input  wire [$clog2(DEPTH)-1:0]            rd_addr_b,
   output logic [cdq_pkg::DATA_W-1:0]         rd_data_a,
   output logic [cdq_pkg::DATA_W-1:0]         rd_data_b
);

   logic [cdq_pkg::DATA_W-1:0] slot_ff [DEPTH];
   logic [cdq_pkg::DATA_W-1:0] rd_a_ff;
   logic [cdq_pkg::DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= slot_ff[rd_addr_a];
         rd_b_ff <= slot_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

/* src/cdq_ctrl.sv */
// Controller: sequences accept, slot read and result handshake.
`default_nettype none
module cdq_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output cdq_pkg::cmd_type  cmd
);

   cdq_pkg::state_type state_ff;
   cdq_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdq_pkg::ST_IDLE: begin
            if (req_valid) state_in = cdq_pkg::ST_READ;
         end
         cdq_pkg::ST_READ: begin
            state_in = cdq_pkg::ST_RESP;
         end
         cdq_pkg::ST_RESP: begin
            if (rsp_ready) state_in = cdq_pkg::ST_IDLE;
         end
         default: begin
            state_in = cdq_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      case (state_ff)
         cdq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take  = req_valid;
         end
         cdq_pkg::ST_READ: begin
            cmd.read = 1'b1;
         end
         cdq_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

/* src/cdq_datapath.sv */
// Datapath: capacity register, head/tail pointers, slot store and result fields.
`default_nettype none
module cdq_datapath #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  cdq_pkg::cmd_type                   cmd,
   input  wire                                csr_wr_en,
   input  wire [cdq_pkg::CAP_W-1:0]           csr_wr_data,
   input  wire [cdq_pkg::FUNC_W-1:0]          req_func,
   input  wire signed [cdq_pkg::DATA_W-1:0]   req_value,
   output logic signed [cdq_pkg::DATA_W-1:0]  rsp_front_value,
   output logic signed [cdq_pkg::DATA_W-1:0]  rsp_rear_value,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   output logic                               rsp_op_error
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CMP_W = (IDX_W + 1 > cdq_pkg::CAP_W) ? IDX_W + 1 : cdq_pkg::CAP_W;

   logic [cdq_pkg::CAP_W-1:0] cap_ff;
   logic [IDX_W-1:0]          head_ff, head_in, tail_ff, tail_in;
   logic                      empty_ff, empty_in;
   logic                      err_ff, err_in;
   logic [IDX_W-1:0]          last_slot, head_n, tail_n;
   logic [CMP_W-1:0]          cap_ext;
   logic                      full_now, is_push, is_pop;
   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [cdq_pkg::DATA_W-1:0] rd_front, rd_rear;

   function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i,
                                            input logic [IDX_W-1:0] last);
      return (i == last) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] prv(input logic [IDX_W-1:0] i,
                                            input logic [IDX_W-1:0] last);
      return (i == '0) ? last : i - 1'b1;
   endfunction

   always_comb begin
      cap_ext = CMP_W'(cap_ff);
      if (cap_ff == '0) begin
         last_slot = '0;
      end else if (cap_ext > CMP_W'(DEPTH)) begin
         last_slot = IDX_W'(DEPTH - 1);
      end else begin
         last_slot = IDX_W'(cap_ext - 1'b1);
      end
   end

   assign head_n   = (head_ff > last_slot) ? '0 : head_ff;
   assign tail_n   = (tail_ff > last_slot) ? '0 : tail_ff;
   assign full_now = !empty_ff && (nxt(tail_n, last_slot) == head_n);
   assign is_push  = (req_func == cdq_pkg::FN_PUSH_FRONT) ||
                     (req_func == cdq_pkg::FN_PUSH_REAR);
   assign is_pop   = (req_func == cdq_pkg::FN_POP_FRONT) ||
                     (req_func == cdq_pkg::FN_POP_REAR);

   always_comb begin
      head_in  = head_n;
      tail_in  = tail_n;
      empty_in = empty_ff;
      err_in   = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      if (is_push) begin
         if (full_now) begin
            err_in = 1'b1;
         end else if (empty_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b0;
            wr_en    = cmd.take;
         end else if (req_func == cdq_pkg::FN_PUSH_FRONT) begin
            head_in = prv(head_n, last_slot);
            wr_addr = head_in;
            wr_en   = cmd.take;
         end else begin
            tail_in = nxt(tail_n, last_slot);
            wr_addr = tail_in;
            wr_en   = cmd.take;
         end
      end else if (is_pop) begin
         if (empty_ff) begin
            err_in = 1'b1;
         end else if (head_n == tail_n) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b1;
         end else if (req_func == cdq_pkg::FN_POP_FRONT) begin
            head_in = nxt(head_n, last_slot);
         end else begin
            tail_in = prv(tail_n, last_slot);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= cdq_pkg::CAP_RESET;
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
         err_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         cap_ff   <= csr_wr_data;
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (cmd.take) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
         err_ff   <= err_in;
      end
   end

   cdq_slot_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en && !csr_wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_value),
      .rd_en     (cmd.read),
      .rd_addr_a (head_ff),
      .rd_addr_b (tail_ff),
      .rd_data_a (rd_front),
      .rd_data_b (rd_rear)
   );

   assign rsp_front_value = empty_ff ? '1 : rd_front;
   assign rsp_rear_value  = empty_ff ? '1 : rd_rear;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = !empty_ff && (nxt(tail_ff, last_slot) == head_ff);
   assign rsp_op_error    = err_ff;

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0) && (tail_ff == '0))
      else $error("empty deque with nonzero pointers");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (head_ff <= last_slot) && (tail_ff <= last_slot))
      else $error("pointer beyond capacity");

   a_err_hold: assert property (@(posedge clock) disable iff (reset)
      cmd.take && err_in && !csr_wr_en |=>
      $stable(head_ff) && $stable(tail_ff) && $stable(empty_ff))
      else $error("failed operation changed deque state");

   a_err_no_write: assert property (@(posedge clock) disable iff (reset)
      err_in |-> !wr_en)
      else $error("slot written on failed push");

endmodule
`default_nettype wire

/* src/circular_deque_top.sv */
// Top level of the circular deque: controller plus datapath.
//
// Double-ended queue in a circular slot store of DEPTH words.
// req channel: req_func (0 push front, 1 push rear, 2 pop front,
// 3 pop rear, other codes peek) and req_value, valid/ready.
// rsp channel: one item per request with front and rear values after
// the operation (-1 when empty), empty and full flags and op_error for
// a push into a full deque or a pop from an empty one.
// csr_wr_en/csr_wr_data set the capacity in use (0 acts as 1, values
// above DEPTH act as DEPTH) and empty the deque; write only when idle.
// Timing: an item is accepted in the idle state, the slot store is read
// the next cycle, and the result is valid the cycle after that. With
// rsp_ready high, a new item waits for the prior result to go; this is set
// by the registered read of the slot store and the one-item controller.
// A stalled result holds until taken; req_ready stays low meanwhile.
// Reset empties the deque and sets the capacity to 16; slot contents
// are not cleared and need no clearing pass.
`default_nettype none
module circular_deque_top #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire [cdq_pkg::FUNC_W-1:0]          req_func,
   input  wire signed [cdq_pkg::DATA_W-1:0]   req_value,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [cdq_pkg::DATA_W-1:0]  rsp_front_value,
   output logic signed [cdq_pkg::DATA_W-1:0]  rsp_rear_value,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full,
   output logic                               rsp_op_error,
   input  wire                                csr_wr_en,
   input  wire [cdq_pkg::CAP_W-1:0]           csr_wr_data
);

   cdq_pkg::cmd_type cmd;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   cdq_datapath #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_op_error    (rsp_op_error)
   );

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for circular_deque_top with a tracking deque scoreboard.
module tb;

   localparam logic [cdq_pkg::FUNC_W-1:0] FN_PEEK = 3'd4;
   localparam int ITEMS_PER_PHASE = 90;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [cdq_pkg::DATA_W-1:0] front_value;
      logic [cdq_pkg::DATA_W-1:0] rear_value;
      logic                       is_empty;
      logic                       is_full;
      logic                       op_error;
   } deque_view_type;

   class deque_tracker;
      logic [cdq_pkg::CAP_W-1:0]  cap_reg;
      int                         head;
      int                         tail;
      bit                         empty;
      logic [cdq_pkg::DATA_W-1:0] slots [cdq_pkg::DEPTH_DEF];
      deque_view_type             expected_views [$];
      int                         errors;

      function new();
         cap_reg = cdq_pkg::CAP_RESET;
         head = 0;
         tail = 0;
         empty = 1;
         errors = 0;
      endfunction

      function int span();
         if (cap_reg == 0) return 1;
         if (cap_reg > cdq_pkg::DEPTH_DEF) return cdq_pkg::DEPTH_DEF;
         return int'(cap_reg);
      endfunction

      function int step_up(int i, int c);
         return (i + 1 >= c) ? 0 : i + 1;
      endfunction

      function int step_down(int i, int c);
         return (i == 0) ? c - 1 : i - 1;
      endfunction

      function bit full_now(int c);
         return !empty && step_up(tail, c) == head;
      endfunction

      function void set_capacity(logic [cdq_pkg::CAP_W-1:0] v);
         cap_reg = v;
         head = 0;
         tail = 0;
         empty = 1;
      endfunction

      function void note_item(logic [cdq_pkg::FUNC_W-1:0] func,
                              logic [cdq_pkg::DATA_W-1:0] value);
         int c;
         deque_view_type v;
         c = span();
         v.op_error = 1'b0;
         if (head >= c) head = 0;
         if (tail >= c) tail = 0;
         case (func)
            cdq_pkg::FN_PUSH_FRONT, cdq_pkg::FN_PUSH_REAR: begin
               if (full_now(c)) begin
                  v.op_error = 1'b1;
               end else if (empty) begin
                  head = 0;
                  tail = 0;
                  empty = 0;
                  slots[0] = value;
               end else if (func == cdq_pkg::FN_PUSH_FRONT) begin
                  head = step_down(head, c);
                  slots[head] = value;
               end else begin
                  tail = step_up(tail, c);
                  slots[tail] = value;
               end
            end
            cdq_pkg::FN_POP_FRONT, cdq_pkg::FN_POP_REAR: begin
               if (empty) begin
                  v.op_error = 1'b1;
               end else if (head == tail) begin
                  head = 0;
                  tail = 0;
                  empty = 1;
               end else if (func == cdq_pkg::FN_POP_FRONT) begin
                  head = step_up(head, c);
               end else begin
                  tail = step_down(tail, c);
               end
            end
            default: ;
         endcase
         v.front_value = empty ? '1 : slots[head];
         v.rear_value  = empty ? '1 : slots[tail];
         v.is_empty    = empty;
         v.is_full     = full_now(c);
         expected_views.push_back(v);
      endfunction

      function int outstanding();
         return expected_views.size();
      endfunction

      function void check_result(deque_view_type got);
         deque_view_type want;
         if (expected_views.size() == 0) begin
            $display("%0t: result item with no item pending", $time);
            errors++;
            return;
         end
         want = expected_views.pop_front();
         if (got.front_value !== want.front_value) begin
            $display("%0t: front_value expected %h actual %h",
                     $time, want.front_value, got.front_value);
            errors++;
         end
         if (got.rear_value !== want.rear_value) begin
            $display("%0t: rear_value expected %h actual %h",
                     $time, want.rear_value, got.rear_value);
            errors++;
         end
         if (got.is_empty !== want.is_empty) begin
            $display("%0t: is_empty expected %b actual %b", $time, want.is_empty, got.is_empty);
            errors++;
         end
         if (got.is_full !== want.is_full) begin
            $display("%0t: is_full expected %b actual %b", $time, want.is_full, got.is_full);
            errors++;
         end
         if (got.op_error !== want.op_error) begin
            $display("%0t: op_error expected %b actual %b", $time, want.op_error, got.op_error);
            errors++;
         end
      endfunction
   endclass

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic [cdq_pkg::FUNC_W-1:0]         req_func = FN_PEEK;
   logic signed [cdq_pkg::DATA_W-1:0]  req_value = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [cdq_pkg::DATA_W-1:0]  rsp_front_value;
   logic signed [cdq_pkg::DATA_W-1:0]  rsp_rear_value;
   logic                               rsp_is_empty;
   logic                               rsp_is_full;
   logic                               rsp_op_error;
   logic                               csr_wr_en = 1'b0;
   logic [cdq_pkg::CAP_W-1:0]          csr_wr_data = '0;

   deque_tracker   tracker;
   bit             steady = 1'b0;
   int             stall_left = 0;
   int             stall_roll;
   int             cycle_count = 0;
   deque_view_type seen;

   circular_deque_top uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_func        (req_func),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_op_error    (rsp_op_error),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.front_value = rsp_front_value;
            seen.rear_value  = rsp_rear_value;
            seen.is_empty    = rsp_is_empty;
            seen.is_full     = rsp_is_full;
            seen.op_error    = rsp_op_error;
            tracker.check_result(seen);
         end
         if (steady) begin
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 20) stall_left = $urandom_range(1, 3);
            else if (stall_roll < 24) stall_left = $urandom_range(10, 40);
         end
      end
   end

   function automatic int pick_gap();
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_item(logic [cdq_pkg::FUNC_W-1:0] func,
                            logic [cdq_pkg::DATA_W-1:0] value);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      tracker.note_item(func, value);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.outstanding() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(logic [cdq_pkg::CAP_W-1:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.set_capacity(v);
   endtask

   task automatic run_random(int count, int push_pct);
      int roll;
      logic [cdq_pkg::FUNC_W-1:0] f;
      logic [cdq_pkg::DATA_W-1:0] v;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < push_pct)
            f = $urandom_range(0, 1) ? cdq_pkg::FN_PUSH_REAR : cdq_pkg::FN_PUSH_FRONT;
         else if (roll < 94)
            f = $urandom_range(0, 1) ? cdq_pkg::FN_POP_REAR : cdq_pkg::FN_POP_FRONT;
         else
            f = FN_PEEK + cdq_pkg::FUNC_W'($urandom_range(0, 3));
         case ($urandom_range(0, 15))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = '1;
            3: v = '0;
            default: v = $urandom;
         endcase
         send_item(f, v);
      end
   endtask

   initial begin
      int phase_caps [10];
      int phase_push [3];
      phase_caps = '{1, 0, 2, 31, 16, 3, 17, 8, 15, 0};
      phase_push = '{70, 35, 55};
      phase_caps[9] = $urandom_range(1, 16);
      tracker = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty deque, extremes, unused codes, drain to empty and refill at slot 0
      send_item(FN_PEEK, 32'h0);
      send_item(cdq_pkg::FN_POP_FRONT, 32'h0);
      send_item(cdq_pkg::FN_POP_REAR, 32'h0);
      send_item(cdq_pkg::FN_PUSH_FRONT, 32'h7FFF_FFFF);
      send_item(cdq_pkg::FN_PUSH_REAR, 32'h8000_0000);
      send_item(cdq_pkg::FN_PUSH_FRONT, 32'hFFFF_FFFF);
      send_item(cdq_pkg::FN_PUSH_REAR, 32'h0);
      send_item(FN_PEEK + 3'd1, 32'h5555_5555);
      send_item(FN_PEEK + 3'd2, 32'hAAAA_AAAA);
      send_item(FN_PEEK + 3'd3, 32'h1);
      send_item(cdq_pkg::FN_POP_FRONT, 32'h0);
      send_item(cdq_pkg::FN_POP_REAR, 32'h0);
      send_item(cdq_pkg::FN_POP_FRONT, 32'h0);
      send_item(cdq_pkg::FN_POP_REAR, 32'h0);
      send_item(cdq_pkg::FN_POP_FRONT, 32'h0);
      send_item(cdq_pkg::FN_PUSH_REAR, 32'h1234_5678);
      send_item(cdq_pkg::FN_PUSH_FRONT, 32'h8765_4321);
      send_item(cdq_pkg::FN_POP_REAR, 32'h0);

      foreach (phase_caps[p]) begin
         write_capacity(cdq_pkg::CAP_W'(phase_caps[p]));
         steady = (p % 3 == 2);
         if (p == 0) begin
            // single slot: full after one push
            send_item(cdq_pkg::FN_PUSH_FRONT, 32'hCAFE_0001);
            send_item(cdq_pkg::FN_PUSH_REAR, 32'hCAFE_0002);
            send_item(FN_PEEK, 32'h0);
            send_item(cdq_pkg::FN_POP_REAR, 32'h0);
            send_item(cdq_pkg::FN_POP_FRONT, 32'h0);
         end
         run_random(ITEMS_PER_PHASE, phase_push[p % 3]);
      end

      steady = 1'b0;
      settle();
      if (tracker.errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
